>>> rtl/ckpr_pkg.sv
// ----------------------------------------------------------------------------
// ckpr_pkg: shared definitions for the color-keyed pixel remap block
// Pixel formats, opcodes, register indexes, masks and default sizes.
// ----------------------------------------------------------------------------
package ckpr_pkg;

	// Default number of substitution table entries.
	localparam int TABLE_ENTRIES_DEF = 16;

	// Field and register widths.
	localparam int PIXEL_W   = 32;
	localparam int COLOR_W   = 24;
	localparam int ENTRY_W   = 4;
	localparam int COUNT_W   = 5;
	localparam int FORMAT_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	// Color masks per pixel format.
	localparam logic [COLOR_W-1:0] MASK_555 = 24'h007FFF;
	localparam logic [COLOR_W-1:0] MASK_16  = 24'h00FFFF;
	localparam logic [COLOR_W-1:0] MASK_24  = 24'hFFFFFF;

	// Pixel formats.
	typedef enum logic [FORMAT_W-1:0] {
		FMT_555 = 2'd0,
		FMT_565 = 2'd1,
		FMT_24  = 2'd2,
		FMT_32  = 2'd3
	} fmt_t;

	// Input transaction opcodes.
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_LOAD  = 1'b1
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_FORMAT   = 2'd0,
		CFG_KEY_COLOR      = 2'd1,
		CFG_ENTRIES_IN_USE = 2'd2
	} cfg_idx_t;

	// True for the two 16-bit formats.
	function automatic logic is_16bit(input fmt_t fmt);
		return (fmt == FMT_555) || (fmt == FMT_565);
	endfunction

endpackage

>>> rtl/color_keyed_pixel_remap.sv
// ----------------------------------------------------------------------------
// color_keyed_pixel_remap: color-keyed blit pixel stage with substitution
// Drops pixels equal to the key color and remaps the others through a small
// table of match/replacement pairs; the highest active matching entry wins.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------------
//  src       src_valid / src_stall     opcode, entry_index, match_value,
//                                      replace_value, source_pixel
//  dst       dst_valid / dst_stall     out_pixel, write_enable
//  cfg       cfg_we                    cfg_index, cfg_data
//
//  One transaction enters per cycle while src_stall is low; an accepted pixel passes
//  the stage registers in order (key check, table compare, priority select, replacement read).
//  Load transactions travel the same stages and produce no output.
//  Reset clears the stage valid bits and the configuration registers; the tables are not cleared.
//  A stall on dst backs up stage by stage; no transaction is dropped or repeated.
//
module color_keyed_pixel_remap #(
	parameter int TABLE_ENTRIES = ckpr_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input transactions
	input  logic                            src_valid,
	output logic                            src_stall,
	input  logic                            opcode,
	input  logic [ckpr_pkg::ENTRY_W-1:0]    entry_index,
	input  logic [ckpr_pkg::PIXEL_W-1:0]    match_value,
	input  logic [ckpr_pkg::PIXEL_W-1:0]    replace_value,
	input  logic [ckpr_pkg::PIXEL_W-1:0]    source_pixel,
	// Output transactions
	output logic                            dst_valid,
	input  logic                            dst_stall,
	output logic [ckpr_pkg::PIXEL_W-1:0]    out_pixel,
	output logic                            write_enable,
	// Configuration writes
	input  logic                            cfg_we,
	input  logic [ckpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ckpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ckpr_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Configuration registers.
	fmt_t               fmt_q;
	logic [COLOR_W-1:0] key_q;
	logic [COUNT_W-1:0] entries_q;

	// Substitution tables; contents are undefined until written.
	logic [PIXEL_W-1:0] match_table_q   [TABLE_ENTRIES];
	logic [PIXEL_W-1:0] replace_table_q [TABLE_ENTRIES];

	// Stage 1: captured transaction with key check done.
	logic               valid_s1, load_s1, keyed_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [ENTRY_W-1:0] entry_s1;
	logic [PIXEL_W-1:0] match_s1, replace_s1;

	// Stage 2: match vector over the active entries.
	logic                     valid_s2, load_s2, keyed_s2;
	logic [COLOR_W-1:0]       color_s2;
	logic [ENTRY_W-1:0]       entry_s2;
	logic [PIXEL_W-1:0]       replace_s2;
	logic [TABLE_ENTRIES-1:0] hit_s2;

	// Stage 3: winning entry index.
	logic               valid_s3, load_s3, keyed_s3, any_s3;
	logic [COLOR_W-1:0] color_s3;
	logic [ENTRY_W-1:0] entry_s3;
	logic [PIXEL_W-1:0] replace_s3;
	logic [IDX_W-1:0]   idx_s3;

	// Stage 4: output register.
	logic               valid_s4;
	logic [PIXEL_W-1:0] pixel_s4;
	logic               we_s4;

	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic [COLOR_W-1:0]       raw_color, lookup_color;
	logic                     raw_keyed;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [IDX_W-1:0]         win_idx;
	logic [PIXEL_W-1:0]       sel_pixel, fmt_pixel;

	// Stage advance: a stage takes new data when it is empty or its contents move on.
	assign ready_s4  = !valid_s4 || !dst_stall;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign src_stall = !ready_s1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_32;
			key_q     <= '0;
			entries_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PIXEL_FORMAT:   fmt_q     <= fmt_t'(cfg_data[FORMAT_W-1:0]);
				CFG_KEY_COLOR:      key_q     <= cfg_data[COLOR_W-1:0];
				CFG_ENTRIES_IN_USE: entries_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Format the source pixel into the lookup color; the key check compares the unmasked raw color.
	always_comb begin
		if (is_16bit(fmt_q)) begin
			raw_color    = {8'h00, source_pixel[15:0]};
			lookup_color = raw_color & ((fmt_q == FMT_555) ? MASK_555 : MASK_16);
		end else begin
			raw_color    = source_pixel[COLOR_W-1:0];
			lookup_color = raw_color & MASK_24;
		end
		raw_keyed = (raw_color == key_q);
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && ready_s1) begin
			load_s1    <= (opcode_t'(opcode) == OP_LOAD);
			keyed_s1   <= raw_keyed;
			color_s1   <= lookup_color;
			entry_s1   <= entry_index;
			match_s1   <= match_value;
			replace_s1 <= replace_value;
		end
	end

	// Compare the lookup color with every active match entry.
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = (i < int'(entries_q)) &&
				(match_table_q[i] == {8'h00, color_s1});
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			load_s2    <= load_s1;
			keyed_s2   <= keyed_s1;
			color_s2   <= color_s1;
			entry_s2   <= entry_s1;
			replace_s2 <= replace_s1;
			hit_s2     <= hit_vec;
		end
	end

	// Match table write: a load updates it as it leaves stage 1, so pixels ahead
	// of it compare against the old contents and pixels behind it the new ones.
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_match
		always_ff @(posedge clk) begin
			if (valid_s1 && ready_s2 && load_s1 && (int'(entry_s1) == g)) begin
				match_table_q[g] <= match_s1;
			end
		end
	end

	// Highest matching index wins.
	always_comb begin
		win_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit_s2[i]) begin
				win_idx = IDX_W'(i);
			end
		end
	end

	// Stage 3 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			load_s3    <= load_s2;
			keyed_s3   <= keyed_s2;
			color_s3   <= color_s2;
			entry_s3   <= entry_s2;
			replace_s3 <= replace_s2;
			any_s3     <= |hit_s2;
			idx_s3     <= win_idx;
		end
	end

	// Replacement table write, at the same pipeline position as its read.
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_replace
		always_ff @(posedge clk) begin
			if (valid_s3 && ready_s4 && load_s3 && (int'(entry_s3) == g)) begin
				replace_table_q[g] <= replace_s3;
			end
		end
	end

	// Read the replacement and cut it to the pixel format.
	always_comb begin
		sel_pixel = any_s3 ? replace_table_q[idx_s3] : {8'h00, color_s3};
		case (fmt_q)
			FMT_555, FMT_565: fmt_pixel = {16'h0000, sel_pixel[15:0]};
			FMT_24:           fmt_pixel = {8'h00, sel_pixel[COLOR_W-1:0]};
			default:          fmt_pixel = sel_pixel;
		endcase
	end

	// Stage 4: output register; loads end at stage 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3 && !load_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && !load_s3 && ready_s4) begin
			pixel_s4 <= keyed_s3 ? '0 : fmt_pixel;
			we_s4    <= !keyed_s3;
		end
	end

	assign dst_valid    = valid_s4;
	assign out_pixel    = pixel_s4;
	assign write_enable = we_s4;

endmodule

>>> rtl/ckpr_checker.sv
// ----------------------------------------------------------------------------
// ckpr_checker: port-level checks for color_keyed_pixel_remap
// Watches the ports of the block over time and reports violations.
// ----------------------------------------------------------------------------
module ckpr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            src_valid,
	input logic                            src_stall,
	input logic                            opcode,
	input logic                            dst_valid,
	input logic                            dst_stall,
	input logic [ckpr_pkg::PIXEL_W-1:0]    out_pixel,
	input logic                            write_enable,
	input logic                            cfg_we,
	input logic [ckpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ckpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ckpr_pkg::*;

	logic       pix_in, pix_out;
	logic [3:0] pending_q;
	logic       narrow_q;

	assign pix_in  = src_valid && !src_stall && (opcode_t'(opcode) == OP_PIXEL);
	assign pix_out = dst_valid && !dst_stall;

	// Pixel transactions accepted and not yet delivered (at most four in flight).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(pix_in) - 4'(pix_out);
		end
	end

	// Shadow of the pixel format: set while a 16-bit format is selected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_q <= 1'b0;
		end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_PIXEL_FORMAT)) begin
			narrow_q <= is_16bit(fmt_t'(cfg_data[FORMAT_W-1:0]));
		end
	end

	// A stalled output transaction holds its payload.
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(out_pixel) && $stable(write_enable))
		else $error("output transaction changed while stalled");

	// Every output comes from an earlier pixel transaction.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> pending_q != 4'd0)
		else $error("output without a pending pixel transaction");

	// A keyed pixel carries a zero pixel value.
	a_keyed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !write_enable |-> out_pixel == '0)
		else $error("keyed output with nonzero pixel");

	// In 16-bit formats the upper half of the output is clear.
	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && narrow_q |-> out_pixel[31:16] == 16'h0000)
		else $error("16-bit format output has upper bits set");

endmodule

bind color_keyed_pixel_remap ckpr_checker u_ckpr_checker (.*);
